>>> rtl/tss_pkg.sv
// Shared types, widths and register indexes for the triangle scanline span unit.
// No dependencies.
package tss_pkg;

	localparam int CW          = 16;                         // coordinate width
	localparam int PROD_W      = 2 * CW;
	localparam int DIV_STEPS   = 4;                          // quotient bits per divider stage
	localparam int DIV_STAGES  = (CW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int EDGE_STAGES = DIV_STAGES + 2;             // multiply, divide, round
	localparam int NSTG        = 2 * EDGE_STAGES + 3;
	localparam int CFG_IDX_W   = 4;
	localparam int OUT_W       = ((2 + 2 * CW) + 7) / 8 * 8;
	localparam int IN_W        = (CW + 7) / 8 * 8;

	localparam logic [CFG_IDX_W-1:0] REG_AX   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_AY   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BX   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BY   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_CX   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_CY   = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(7);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [CW-1:0]        ucoord_t;
	typedef logic signed [CW:0]   diff_t;
	typedef logic [CW-2:0]        canvas_t;

	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
		coord_t row;
		logic   inb;
	} sorted_t;

	typedef struct packed {
		coord_t  xa;
		diff_t   dx;
		ucoord_t t;
		ucoord_t d;
	} edge_req_t;

	typedef struct packed {
		logic   inb;
		logic   covered;
		logic   flat;
		coord_t fmin;
		coord_t fmax;
	} span_ctl_t;

	function automatic diff_t dsub(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

endpackage

>>> rtl/tss_sort.sv
// Vertex bounds check and three-way sort by y (combinational, feeds stage 1).
// Depends on tss_pkg.
module tss_sort (
	input  tss_pkg::coord_t  ax,
	input  tss_pkg::coord_t  ay,
	input  tss_pkg::coord_t  bx,
	input  tss_pkg::coord_t  by,
	input  tss_pkg::coord_t  cx,
	input  tss_pkg::coord_t  cy,
	input  tss_pkg::canvas_t cols,
	input  tss_pkg::canvas_t rows,
	input  tss_pkg::coord_t  row,
	output tss_pkg::sorted_t srt
);
	import tss_pkg::*;

	function automatic logic inside_canvas(coord_t x, coord_t y, canvas_t c, canvas_t r);
		return !x[CW-1] && !y[CW-1] && (CW'(x) <= CW'(c)) && (CW'(y) <= CW'(r));
	endfunction

	always_comb begin
		coord_t x0, y0, x1, y1, x2, y2, tx, ty;
		x0 = ax; y0 = ay; x1 = bx; y1 = by; x2 = cx; y2 = cy;
		tx = '0; ty = '0;
		// same compare-swap order as the spec: (0,2), (0,1), (1,2), strict
		if (y0 > y2) begin
			tx = x0; ty = y0; x0 = x2; y0 = y2; x2 = tx; y2 = ty;
		end
		if (y0 > y1) begin
			tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
		end
		if (y1 > y2) begin
			tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
		end
		srt.x0  = x0; srt.y0 = y0;
		srt.x1  = x1; srt.y1 = y1;
		srt.x2  = x2; srt.y2 = y2;
		srt.row = row;
		srt.inb = inside_canvas(ax, ay, cols, rows) && inside_canvas(bx, by, cols, rows)
			&& inside_canvas(cx, cy, cols, rows);
	end

endmodule

>>> rtl/tss_edge.sv
// Pipelined edge x: xa + dx*t/d, exact, rounded half away from zero.
// Multiply stage, restoring divider stages, rounding stage. Depends on tss_pkg.
module tss_edge (
	input  logic                             clk,
	input  logic [tss_pkg::EDGE_STAGES-1:0]  en,
	input  tss_pkg::edge_req_t               req,
	output tss_pkg::coord_t                  x
);
	import tss_pkg::*;

	ucoord_t           mag;
	logic              neg_s1;
	ucoord_t           d_s1;
	coord_t            xa_s1;
	logic [PROD_W-1:0] prod_s1;

	ucoord_t rem_s2 [DIV_STAGES];
	ucoord_t low_s2 [DIV_STAGES];
	ucoord_t quo_s2 [DIV_STAGES];
	ucoord_t d_s2   [DIV_STAGES];
	coord_t  xa_s2  [DIV_STAGES];
	logic    neg_s2 [DIV_STAGES];

	coord_t  xr;
	coord_t  x_sr;

	// |dx| never exceeds 2^CW-1
	assign mag = req.dx[CW] ? CW'(-req.dx) : CW'(req.dx);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s1  <= req.dx[CW];
			d_s1    <= req.d;
			xa_s1   <= req.xa;
			prod_s1 <= mag * req.t;
		end
	end

	// quotient <= |dx| since t <= d, so the upper half is already below d
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		ucoord_t rem_i, low_i, quo_i, d_i, rem_o, low_o, quo_o;
		coord_t  xa_i;
		logic    neg_i;

		if (k == 0) begin : g_first
			assign rem_i = prod_s1[PROD_W-1:CW];
			assign low_i = prod_s1[CW-1:0];
			assign quo_i = '0;
			assign d_i   = d_s1;
			assign xa_i  = xa_s1;
			assign neg_i = neg_s1;
		end else begin : g_next
			assign rem_i = rem_s2[k-1];
			assign low_i = low_s2[k-1];
			assign quo_i = quo_s2[k-1];
			assign d_i   = d_s2[k-1];
			assign xa_i  = xa_s2[k-1];
			assign neg_i = neg_s2[k-1];
		end

		always_comb begin
			logic [CW:0] r2;
			r2    = '0;
			rem_o = rem_i;
			low_o = low_i;
			quo_o = quo_i;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (k * DIV_STEPS + j < CW) begin
					r2    = {rem_o, low_o[CW-1]};
					low_o = {low_o[CW-2:0], 1'b0};
					if (r2 >= {1'b0, d_i}) begin
						rem_o = CW'(r2 - {1'b0, d_i});
						quo_o = {quo_o[CW-2:0], 1'b1};
					end else begin
						rem_o = r2[CW-1:0];
						quo_o = {quo_o[CW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				rem_s2[k] <= rem_o;
				low_s2[k] <= low_o;
				quo_s2[k] <= quo_o;
				d_s2[k]   <= d_i;
				xa_s2[k]  <= xa_i;
				neg_s2[k] <= neg_i;
			end
		end
	end

	// floor for negative dx, then round half away from zero
	always_comb begin
		logic signed [CW+1:0] qi, vi;
		ucoord_t              r;
		logic [CW:0]          r2x;
		ucoord_t              q, rm, d;
		q  = quo_s2[DIV_STAGES-1];
		rm = rem_s2[DIV_STAGES-1];
		d  = d_s2[DIV_STAGES-1];
		r  = rm;
		if (neg_s2[DIV_STAGES-1]) begin
			if (rm != '0) begin
				qi = ~$signed({2'b00, q});
				r  = d - rm;
			end else begin
				qi = -$signed({2'b00, q});
			end
		end else begin
			qi = $signed({2'b00, q});
		end
		vi  = (CW+2)'(xa_s2[DIV_STAGES-1]) + qi;
		r2x = {r, 1'b0};
		if (!vi[CW+1]) begin
			if (r != '0 && r2x >= {1'b0, d})
				vi = vi + (CW+2)'(1);
		end else if (r2x > {1'b0, d}) begin
			vi = vi + (CW+2)'(1);
		end
		xr = CW'(vi);
	end

	always_ff @(posedge clk) begin
		if (en[EDGE_STAGES-1])
			x_sr <= xr;
	end

	assign x = x_sr;

endmodule

>>> rtl/triangle_scanline_span.sv
// Triangle scanline span unit, top level: config registers, stage control, span select.
// Depends on tss_pkg, tss_sort, tss_edge.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata: row
//  m_*      out  m_tvalid / m_tready    m_tdata: in_bounds, covered, span_start, span_end
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One scanline enters per cycle while the output is not stalled; the path runs through two
// chained edge pipelines: split x first, then both span edges.
// Each stage holds a valid bit; a stage loads when empty or when the next one moves,
// so a stalled output fills bubbles upstream and nothing is dropped or repeated.
// Reset clears the valid bits and the config registers; cfg_ready is always high.
module triangle_scanline_span (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tss_pkg::IN_W-1:0]        s_tdata,   // [15:0] row
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tss_pkg::OUT_W-1:0]       m_tdata,   // [0] in_bounds, [1] covered,
	                                                   // [17:2] span_start, [33:18] span_end
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tss_pkg::CW-1:0]          cfg_data
);
	import tss_pkg::*;

	localparam int E = EDGE_STAGES;

	coord_t  ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	canvas_t cols_q, rows_q;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	sorted_t   srt;
	sorted_t   sort_s1;
	sorted_t   sort_s2 [E];      // rides along the split-x pipeline
	edge_req_t req_x4;
	coord_t    x4;

	span_ctl_t ctl_c;
	edge_req_t req0_c, req1_c;
	span_ctl_t ctl_s8;
	edge_req_t req0_s8, req1_s8;
	span_ctl_t ctl_s9 [E];       // rides along the span edge pipelines
	coord_t    e0, e1;
	coord_t    lo_c, hi_c;

	logic [OUT_W-1:0] out_c;
	logic [OUT_W-1:0] out_s15;

	// ---- config registers ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
			cx_q <= '0; cy_q <= '0; cols_q <= '0; rows_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AX:   ax_q   <= cfg_data;
				REG_AY:   ay_q   <= cfg_data;
				REG_BX:   bx_q   <= cfg_data;
				REG_BY:   by_q   <= cfg_data;
				REG_CX:   cx_q   <= cfg_data;
				REG_CY:   cy_q   <= cfg_data;
				REG_COLS: cols_q <= cfg_data[CW-2:0];
				REG_ROWS: rows_q <= cfg_data[CW-2:0];
				default: ;   // out-of-range index dropped
			endcase
		end
	end

	// ---- stage control: ready ripples back from the output register ----
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= s_tvalid;
			for (int k = 1; k < NSTG; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NSTG-1];

	// ---- stage 1: bounds and sort ----
	tss_sort u_sort (
		.ax(ax_q), .ay(ay_q), .bx(bx_q), .by(by_q), .cx(cx_q), .cy(cy_q),
		.cols(cols_q), .rows(rows_q), .row(s_tdata[CW-1:0]), .srt(srt)
	);

	always_ff @(posedge clk) begin
		if (en[0])
			sort_s1 <= srt;
	end

	// ---- split point x on the long edge at the middle vertex's y ----
	always_comb begin
		req_x4.xa = sort_s1.x0;
		req_x4.dx = dsub(sort_s1.x2, sort_s1.x0);
		req_x4.t  = ucoord_t'(dsub(sort_s1.y1, sort_s1.y0));
		req_x4.d  = ucoord_t'(dsub(sort_s1.y2, sort_s1.y0));
	end

	tss_edge u_x4 (.clk(clk), .en(en[E:1]), .req(req_x4), .x(x4));

	for (genvar k = 0; k < E; k++) begin : g_sort_pipe
		always_ff @(posedge clk) begin
			if (en[k+1])
				sort_s2[k] <= (k == 0) ? sort_s1 : sort_s2[(k == 0) ? 0 : k-1];
		end
	end

	// ---- case select: pick both active edges for this row ----
	always_comb begin
		sorted_t s;
		coord_t  mn, mx;
		s  = sort_s2[E-1];
		mn = (s.x0 < s.x1) ? s.x0 : s.x1;
		mn = (mn < s.x2) ? mn : s.x2;
		mx = (s.x0 > s.x1) ? s.x0 : s.x1;
		mx = (mx > s.x2) ? mx : s.x2;

		ctl_c.inb     = s.inb;
		ctl_c.covered = (s.row >= s.y0) && (s.row <= s.y2);
		ctl_c.flat    = (s.y0 == s.y2);
		ctl_c.fmin    = mn;
		ctl_c.fmax    = mx;

		if (s.y1 == s.y2) begin
			// flat bottom: both edges leave the top vertex
			req0_c.xa = s.x0; req0_c.dx = dsub(s.x1, s.x0);
			req1_c.xa = s.x0; req1_c.dx = dsub(s.x2, s.x0);
			req0_c.d  = ucoord_t'(dsub(s.y1, s.y0));
			req0_c.t  = ucoord_t'(dsub(s.row, s.y0));
		end else if (s.y0 == s.y1) begin
			// flat top: both edges run to the bottom vertex
			req0_c.xa = s.x0; req0_c.dx = dsub(s.x2, s.x0);
			req1_c.xa = s.x1; req1_c.dx = dsub(s.x2, s.x1);
			req0_c.d  = ucoord_t'(dsub(s.y2, s.y0));
			req0_c.t  = ucoord_t'(dsub(s.row, s.y0));
		end else if (s.row <= s.y1) begin
			// upper half of a split triangle
			req0_c.xa = s.x0; req0_c.dx = dsub(s.x1, s.x0);
			req1_c.xa = s.x0; req1_c.dx = dsub(x4, s.x0);
			req0_c.d  = ucoord_t'(dsub(s.y1, s.y0));
			req0_c.t  = ucoord_t'(dsub(s.row, s.y0));
		end else begin
			// lower half
			req0_c.xa = s.x1; req0_c.dx = dsub(s.x2, s.x1);
			req1_c.xa = x4;   req1_c.dx = dsub(s.x2, x4);
			req0_c.d  = ucoord_t'(dsub(s.y2, s.y1));
			req0_c.t  = ucoord_t'(dsub(s.row, s.y1));
		end
		req1_c.d = req0_c.d;
		req1_c.t = req0_c.t;
	end

	always_ff @(posedge clk) begin
		if (en[E+1]) begin
			ctl_s8  <= ctl_c;
			req0_s8 <= req0_c;
			req1_s8 <= req1_c;
		end
	end

	// ---- span edges ----
	tss_edge u_e0 (.clk(clk), .en(en[2*E+1:E+2]), .req(req0_s8), .x(e0));
	tss_edge u_e1 (.clk(clk), .en(en[2*E+1:E+2]), .req(req1_s8), .x(e1));

	for (genvar k = 0; k < E; k++) begin : g_ctl_pipe
		always_ff @(posedge clk) begin
			if (en[E+2+k])
				ctl_s9[k] <= (k == 0) ? ctl_s8 : ctl_s9[(k == 0) ? 0 : k-1];
		end
	end

	// ---- span order and output register ----
	always_comb begin
		span_ctl_t c;
		c = ctl_s9[E-1];
		if (c.flat) begin
			lo_c = c.fmin;
			hi_c = c.fmax;
		end else begin
			lo_c = (e0 < e1) ? e0 : e1;
			hi_c = (e0 < e1) ? e1 : e0;
		end
		if (!c.covered) begin
			lo_c = '0;
			hi_c = '0;
		end
		out_c = OUT_W'({hi_c, lo_c, c.covered, c.inb});
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1])
			out_s15 <= out_c;
	end

	assign m_tdata = out_s15;

endmodule

>>> rtl/tss_chk.sv
// Port-level checker for the triangle scanline span unit, bound to the top level.
// Depends on tss_pkg and triangle_scanline_span.
module tss_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tss_pkg::OUT_W-1:0]       m_tdata
);
	import tss_pkg::*;

	logic   cov, inb;
	coord_t sp_lo, sp_hi;

	assign inb   = m_tdata[0];
	assign cov   = m_tdata[1];
	assign sp_lo = m_tdata[CW+1:2];
	assign sp_hi = m_tdata[2*CW+1:CW+2];

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// uncovered rows report an empty span of zeros
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !cov |-> sp_lo == '0 && sp_hi == '0)
		else $error("uncovered row with nonzero span");

	// span is ordered
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cov |-> sp_lo <= sp_hi)
		else $error("span start beyond span end");

	// all vertices at x >= 0 keep every edge at x >= 0
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cov && inb |-> !sp_lo[CW-1])
		else $error("in-bounds triangle with negative span start");

endmodule

bind triangle_scanline_span tss_chk u_tss_chk (.*);

>>> verif/tb_triangle_scanline_span.sv
// Self-checking testbench for triangle_scanline_span: random and directed scanlines
// against an integer span predictor, with idling and back-pressure on both streams.
// Depends on tss_pkg and the triangle_scanline_span RTL.
module tb_triangle_scanline_span;
	import tss_pkg::*;

	// packed from the top bit down: span_end is highest, in_bounds is bit 0
	typedef struct packed {
		coord_t span_end;
		coord_t span_start;
		logic   covered;
		logic   in_bounds;
	} span_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0]     cfg_data = '0;

	// shadow copy of the triangle and canvas
	coord_t  vert_x[3];
	coord_t  vert_y[3];
	canvas_t canvas_cols;
	canvas_t canvas_rows;

	span_t   expected_spans[$];
	int      errors = 0;
	int      rows_sent = 0;
	int      spans_seen = 0;
	int      covered_seen = 0;
	int      triangles = 0;
	bit      idle_on = 1'b1;
	int      hold_req = 0;   // long sink hold-off request, cycles

	triangle_scanline_span DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// x on an edge: xa + dx*t/d, exact, halves rounded away from zero
	function automatic longint edge_at(longint xa, longint dx, longint t, longint d);
		longint a, p, q, r, qi, v;
		bit     neg;
		neg = dx < 0;
		a = neg ? -dx : dx;
		p = a * t;
		q = p / d;
		r = p % d;
		if (neg) begin
			if (r != 0) begin
				qi = -q - 1;
				r = d - r;
			end else
				qi = -q;
		end else
			qi = q;
		v = xa + qi;
		if (v >= 0) begin
			if (r != 0 && 2 * r >= d)
				v++;
		end else if (2 * r > d)
			v++;
		return v;
	endfunction

	function automatic span_t predict_span(coord_t row_in);
		longint x[3], y[3], tx, ty, e0, e1, split_x, row, d, t;
		span_t  res;
		res = '0;
		res.in_bounds = 1'b1;
		row = row_in;
		for (int i = 0; i < 3; i++) begin
			x[i] = vert_x[i];
			y[i] = vert_y[i];
			if (x[i] < 0 || x[i] > canvas_cols || y[i] < 0 || y[i] > canvas_rows)
				res.in_bounds = 1'b0;
		end
		// same three compare-swaps, in the same order as the block
		if (y[0] > y[2]) begin tx = x[0]; ty = y[0]; x[0] = x[2]; y[0] = y[2]; x[2] = tx; y[2] = ty; end
		if (y[0] > y[1]) begin tx = x[0]; ty = y[0]; x[0] = x[1]; y[0] = y[1]; x[1] = tx; y[1] = ty; end
		if (y[1] > y[2]) begin tx = x[1]; ty = y[1]; x[1] = x[2]; y[1] = y[2]; x[2] = tx; y[2] = ty; end
		if (row < y[0] || row > y[2])
			return res;
		if (y[0] == y[2]) begin
			e0 = x[0] < x[1] ? x[0] : x[1];
			e0 = e0 < x[2] ? e0 : x[2];
			e1 = x[0] > x[1] ? x[0] : x[1];
			e1 = e1 > x[2] ? e1 : x[2];
		end else if (y[1] == y[2]) begin
			d = y[1] - y[0]; t = row - y[0];
			e0 = edge_at(x[0], x[1] - x[0], t, d);
			e1 = edge_at(x[0], x[2] - x[0], t, d);
		end else if (y[0] == y[1]) begin
			d = y[2] - y[0]; t = row - y[0];
			e0 = edge_at(x[0], x[2] - x[0], t, d);
			e1 = edge_at(x[1], x[2] - x[1], t, d);
		end else begin
			split_x = edge_at(x[0], x[2] - x[0], y[1] - y[0], y[2] - y[0]);
			if (row <= y[1]) begin
				d = y[1] - y[0]; t = row - y[0];
				e0 = edge_at(x[0], x[1] - x[0], t, d);
				e1 = edge_at(x[0], split_x - x[0], t, d);
			end else begin
				d = y[2] - y[1]; t = row - y[1];
				e0 = edge_at(x[1], x[2] - x[1], t, d);
				e1 = edge_at(split_x, x[2] - split_x, t, d);
			end
		end
		res.covered = 1'b1;
		res.span_start = coord_t'(e0 < e1 ? e0 : e1);
		res.span_end   = coord_t'(e0 < e1 ? e1 : e0);
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", field, got, want, spans_seen);
		errors++;
	endtask

	// Handshakes are sampled at the falling edge; inputs only move at rising edges.
	task automatic send_row(coord_t row);
		bit ok;
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(row);
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		expected_spans.push_back(predict_span(row));
		rows_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_spans.size() != 0)
			@(posedge clk);
		repeat (NSTG + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		case (idx)
			REG_AX:   vert_x[0] = coord_t'(value);
			REG_AY:   vert_y[0] = coord_t'(value);
			REG_BX:   vert_x[1] = coord_t'(value);
			REG_BY:   vert_y[1] = coord_t'(value);
			REG_CX:   vert_x[2] = coord_t'(value);
			REG_CY:   vert_y[2] = coord_t'(value);
			REG_COLS: canvas_cols = canvas_t'(value);
			REG_ROWS: canvas_rows = canvas_t'(value);
			default: ;   // out-of-map indexes are dropped
		endcase
		@(posedge clk);
	endtask

	task automatic load_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy, canvas_t cols, canvas_t rows);
		drain();
		write_reg(REG_AX, ax);
		write_reg(REG_AY, ay);
		write_reg(REG_BX, bx);
		write_reg(REG_BY, by);
		write_reg(REG_CX, cx);
		write_reg(REG_CY, cy);
		write_reg(REG_COLS, CW'(cols));
		write_reg(REG_ROWS, CW'(rows));
		triangles++;
	endtask

	// rows around the vertex levels: just above, each vertex, just below
	task automatic sweep_levels();
		longint lo, hi;
		lo = vert_y[0] < vert_y[1] ? vert_y[0] : vert_y[1];
		lo = lo < vert_y[2] ? lo : vert_y[2];
		hi = vert_y[0] > vert_y[1] ? vert_y[0] : vert_y[1];
		hi = hi > vert_y[2] ? hi : vert_y[2];
		if (lo > -32768) send_row(coord_t'(lo - 1));
		for (int i = 0; i < 3; i++)
			send_row(vert_y[i]);
		if (hi < 32767) send_row(coord_t'(hi + 1));
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom_range(0, 60) - 20);
			1: return coord_t'($urandom_range(0, 1000));
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic random_triangle();
		int      mode;
		coord_t  v[6];
		canvas_t cols, rows;
		mode = $urandom_range(0, 2);
		for (int i = 0; i < 6; i++)
			v[i] = rand_coord(mode);
		// force flat tops, flat bottoms and zero-height shapes now and then
		case ($urandom_range(0, 5))
			0: v[3] = v[1];
			1: v[5] = v[3];
			2: begin v[3] = v[1]; v[5] = v[1]; end
			default: ;
		endcase
		if ($urandom_range(0, 1) == 0) begin
			cols = canvas_t'($urandom_range(0, 1200));
			rows = canvas_t'($urandom_range(0, 1200));
		end else begin
			cols = canvas_t'($urandom);
			rows = canvas_t'($urandom);
		end
		load_triangle(v[0], v[1], v[2], v[3], v[4], v[5], cols, rows);
	endtask

	// mostly rows near the triangle, some anywhere in the field
	task automatic random_rows(int count);
		longint lo, hi, r;
		lo = vert_y[0] < vert_y[1] ? vert_y[0] : vert_y[1];
		lo = lo < vert_y[2] ? lo : vert_y[2];
		hi = vert_y[0] > vert_y[1] ? vert_y[0] : vert_y[1];
		hi = hi > vert_y[2] ? hi : vert_y[2];
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0)
				r = longint'(coord_t'($urandom));
			else
				r = lo - 2 + longint'($urandom_range(0, int'(hi - lo + 4)));
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			send_row(coord_t'(r));
		end
	endtask

	task automatic test_directed();
		// general split with half-way roundings, vertices on the canvas edge
		load_triangle(0, 0, 10, 4, 3, 8, 10, 8);
		sweep_levels();
		send_row(1);
		send_row(6);
		// flat top; one vertex off the canvas
		load_triangle(0, 0, 6, 0, -1, 2, 20, 20);
		sweep_levels();
		// flat bottom with a negative half that rounds away from zero
		load_triangle(0, 0, -1, 2, 0, 2, 0, 0);
		send_row(1);
		sweep_levels();
		// zero height: spans min to max x
		load_triangle(7, 5, -4, 5, 3, 5, 32767, 32767);
		sweep_levels();
		// coordinate extremes, row field extremes
		load_triangle(-32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767);
		send_row(-32768);
		send_row(0);
		send_row(32767);
		// indexes past the register map must be dropped
		drain();
		for (int idx = int'(REG_ROWS) + 1; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), CW'($urandom));
		send_row(0);
		send_row(-1);
	endtask

	task automatic test_random();
		for (int k = 0; k < 17; k++) begin
			random_triangle();
			random_rows($urandom_range(10, 40));
		end
	endtask

	// sink holds off while rows keep coming, so the pipeline fills and stalls the input
	task automatic test_backpressure();
		random_triangle();
		hold_req = 300;
		random_rows(60);
		drain();   // sender waits for every span
		random_rows(20);
	endtask

	task automatic test_steady();
		drain();
		idle_on = 1'b0;
		random_triangle();
		random_rows(150);
		idle_on = 1'b1;
	endtask

	// sink: random hold-off bursts, or a long one on request
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				burst = hold_req;
				hold_req = 0;
			end else if (burst == 0 && idle_on && $urandom_range(0, 3) == 0)
				burst = $urandom_range(1, 9);
			if (burst > 0) begin
				m_tready <= 1'b0;
				burst--;
			end else
				m_tready <= 1'b1;
		end
	end

	// span checker: a transfer is seen at the falling edge before it completes
	initial begin
		span_t got, want;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = span_t'(m_tdata[2 + 2 * CW - 1:0]);
				spans_seen++;
				if (expected_spans.size() == 0) begin
					$display("MISMATCH: span %0d arrived with none expected", spans_seen);
					errors++;
				end else begin
					want = expected_spans.pop_front();
					if (got.in_bounds !== want.in_bounds)
						report_mismatch("in_bounds", got.in_bounds, want.in_bounds);
					if (got.covered !== want.covered)
						report_mismatch("covered", got.covered, want.covered);
					if (got.span_start !== want.span_start)
						report_mismatch("span_start", got.span_start, want.span_start);
					if (got.span_end !== want.span_end)
						report_mismatch("span_end", got.span_end, want.span_end);
					if (want.covered)
						covered_seen++;
				end
				@(posedge clk);
			end
		end
	end

	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		for (int i = 0; i < 3; i++) begin
			vert_x[i] = '0;
			vert_y[i] = '0;
		end
		canvas_cols = '0;
		canvas_rows = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_row(0);   // reset registers: a point triangle at the origin
		send_row(1);
		test_directed();
		test_random();
		test_backpressure();
		test_random();
		test_steady();
		drain();
		if (expected_spans.size() != 0) begin
			$display("MISMATCH: %0d spans never arrived", expected_spans.size());
			errors++;
		end
		$display("Run covered %0d scanlines over %0d triangles, %0d covered rows checked",
			rows_sent, triangles, covered_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/tss_pkg.sv
rtl/tss_sort.sv
rtl/tss_edge.sv
rtl/triangle_scanline_span.sv
rtl/tss_chk.sv
verif/tb_triangle_scanline_span.sv
